FILE: sv/vna_pkg.sv
package vna_pkg;

   localparam int unsigned DEF_MAX_VERTICES = 1024;

   localparam int IDX_W   = 10;
   localparam int COORD_W = 24;
   localparam int EDGE_W  = COORD_W + 1;
   localparam int CROSS_W = 2 * EDGE_W + 1;
   localparam int MAG_W   = CROSS_W - 1;
   localparam int SMAG_W  = 31;
   localparam int MUL_W   = 33;
   localparam int SQ_W    = 64;
   localparam int ROOT_W  = 32;
   localparam int FRAC_W  = 14;
   localparam int DVD_W   = SMAG_W + FRAC_W;
   localparam int DVS_W   = ROOT_W + 1;
   localparam int NORM_W  = 16;
   localparam int SUM_W   = 32;
   localparam int CNT_W   = 16;
   localparam int REQ_W   = 112;
   localparam int RSP_W   = 3 * NORM_W;

   localparam logic [NORM_W-1:0] ONE_Q14 = 16'd16384;
   localparam logic [CNT_W-1:0]  CNT_MAX = 16'hFFFF;

   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_FACE  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_EDGE,
      ST_MUL,
      ST_ACC,
      ST_MAG,
      ST_SHIFT,
      ST_SQ,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_AVG_RD,
      ST_AVG_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } coord_type;

   typedef struct packed {
      logic [CNT_W-1:0]        cnt;
      logic signed [SUM_W-1:0] z;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] x;
   } acc_type;

endpackage

FILE: sv/vertex_normal_accumulator.sv
// Vertex normal accumulator.
// Input channel req_*: tuser carries the op (store vertex, face, read vertex),
// tdata the index, coordinates and corners. One item is worked at a time;
// req_tready is high only while the engine is idle.
// Result channel rsp_*: one transfer for each face and each vertex read,
// none for a store. tuser carries kind and the invalid flag.
// A store is written as it is accepted. Each division is a start state, 45 bit
// steps and a done pulse. A vertex read runs three divisions to its result; an
// unused vertex skips them. A face runs the corner reads, edges, the cross
// product, up to 19 shift steps, the squares, the square root, three divisions
// and the corner updates to its result; a zero-area face skips root and
// divisions. A single shared 33x33 multiplier forms the cross product and the
// squares; one iterative root unit and one iterative divider follow.
// After reset the accumulator memory is swept to zero, one entry per cycle,
// before the first item is taken. Vertex coordinates are not cleared. A result
// waits in its state until rsp_tready; no new item is taken meanwhile.
module vertex_normal_accumulator import vna_pkg::*; #(
   parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
   input  logic [REQ_W-1:0] req_tdata,
   // op
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [RSP_W-1:0] rsp_tdata,
   // kind, invalid
   output logic [1:0]       rsp_tuser
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

   state_type state_ff, state_in;

   // input decode
   op_type           in_op;
   logic [IDX_W-1:0] in_vi, in_a, in_b, in_c;
   coord_type        in_coord;
   logic [16:0]      vi17, a17, b17, c17;
   logic             accept;

   assign in_op      = op_type'(req_tuser);
   assign in_vi      = req_tdata[9:0];
   assign in_coord.x = req_tdata[33:10];
   assign in_coord.y = req_tdata[57:34];
   assign in_coord.z = req_tdata[81:58];
   assign in_a       = req_tdata[91:82];
   assign in_b       = req_tdata[101:92];
   assign in_c       = req_tdata[111:102];
   assign vi17       = 17'(in_vi);
   assign a17        = 17'(in_a);
   assign b17        = 17'(in_b);
   assign c17        = 17'(in_c);
   assign accept     = req_tvalid && req_tready;

   logic vi_ok, face_ok;
   assign vi_ok   = vi17 < MAXV;
   assign face_ok = (a17 < MAXV) && (b17 < MAXV) && (c17 < MAXV);

   // memories
   coord_type coord_mem [MAX_VERTICES];
   acc_type   acc_mem [MAX_VERTICES];
   coord_type coord_q_ff, coord_wdata;
   acc_type   acc_q_ff, acc_wdata;
   logic [AW-1:0] coord_waddr, coord_raddr, acc_waddr, acc_raddr;
   logic          coord_we, acc_we;

   always_ff @(posedge clock) begin
      if (coord_we) begin
         coord_mem[coord_waddr] <= coord_wdata;
      end
      coord_q_ff <= coord_mem[coord_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_q_ff <= acc_mem[acc_raddr];
   end

   // datapath registers
   logic [AW-1:0]              clr_ff;
   logic [AW-1:0]              addr_ff [3];
   logic                       face_ff;
   logic                       kind_ff;
   logic                       inv_ff;
   logic [2:0]                 mul_ff;
   logic [1:0]                 comp_ff;
   coord_type                  va_ff;
   logic signed [EDGE_W-1:0]   e0_ff [3];
   logic signed [EDGE_W-1:0]   e1_ff [3];
   logic signed [CROSS_W-1:0]  n_ff [3];
   logic [MAG_W-1:0]           m_ff [3];
   logic                       sgn_ff [3];
   logic signed [2*MUL_W-1:0]  prod_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [ROOT_W-1:0]          len_ff;
   logic signed [NORM_W-1:0]   r_ff [3];
   logic signed [SUM_W-1:0]    avg_sum_ff [3];
   logic [CNT_W-1:0]           avg_cnt_ff;

   // shared multiplier operands
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [SQ_W-1:0]         sq_in;
   logic                    too_big;
   logic signed [CROSS_W-1:0] prod_x;

   always_comb begin
      mul_a = {{(MUL_W-EDGE_W){e0_ff[0][EDGE_W-1]}}, e0_ff[0]};
      mul_b = {{(MUL_W-EDGE_W){e1_ff[1][EDGE_W-1]}}, e1_ff[1]};
      if (state_ff == ST_SQ) begin
         mul_a = {2'b00, m_ff[comp_ff][SMAG_W-1:0]};
         mul_b = {2'b00, m_ff[comp_ff][SMAG_W-1:0]};
      end else begin
         case (mul_ff)
            3'd0: begin
               mul_a = {{(MUL_W-EDGE_W){e0_ff[1][EDGE_W-1]}}, e0_ff[1]};
               mul_b = {{(MUL_W-EDGE_W){e1_ff[2][EDGE_W-1]}}, e1_ff[2]};
            end
            3'd1: begin
               mul_a = {{(MUL_W-EDGE_W){e1_ff[1][EDGE_W-1]}}, e1_ff[1]};
               mul_b = {{(MUL_W-EDGE_W){e0_ff[2][EDGE_W-1]}}, e0_ff[2]};
            end
            3'd2: begin
               mul_a = {{(MUL_W-EDGE_W){e0_ff[2][EDGE_W-1]}}, e0_ff[2]};
               mul_b = {{(MUL_W-EDGE_W){e1_ff[0][EDGE_W-1]}}, e1_ff[0]};
            end
            3'd3: begin
               mul_a = {{(MUL_W-EDGE_W){e1_ff[2][EDGE_W-1]}}, e1_ff[2]};
               mul_b = {{(MUL_W-EDGE_W){e0_ff[0][EDGE_W-1]}}, e0_ff[0]};
            end
            3'd5: begin
               mul_a = {{(MUL_W-EDGE_W){e1_ff[0][EDGE_W-1]}}, e1_ff[0]};
               mul_b = {{(MUL_W-EDGE_W){e0_ff[1][EDGE_W-1]}}, e0_ff[1]};
            end
            default: ;
         endcase
      end
   end

   assign prod_x  = {prod_ff[CROSS_W-2], prod_ff[CROSS_W-2:0]};
   assign sq_in   = sq_ff + prod_ff[SQ_W-1:0];
   assign too_big = (|m_ff[0][MAG_W-1:SMAG_W]) || (|m_ff[1][MAG_W-1:SMAG_W])
                 || (|m_ff[2][MAG_W-1:SMAG_W]);

   // root and divider
   logic              sqrt_go, div_go;
   logic [ROOT_W-1:0] root;
   unit_stat_type     sqrt_stat, div_stat;
   logic [DVD_W-1:0]  div_dvd, quo;
   logic [DVS_W-1:0]  div_dvs;
   logic [SUM_W-1:0]  avg_mag;
   logic [NORM_W-1:0] q_clip;
   logic              q_neg;
   logic signed [NORM_W-1:0] q_res;

   assign avg_mag = avg_sum_ff[comp_ff][SUM_W-1] ? SUM_W'(-avg_sum_ff[comp_ff])
                                                 : avg_sum_ff[comp_ff];
   assign div_dvd = face_ff ? {m_ff[comp_ff][SMAG_W-1:0], {FRAC_W{1'b0}}}
                            : {{(DVD_W-SUM_W){1'b0}}, avg_mag};
   assign div_dvs = face_ff ? {1'b0, len_ff} : {{(DVS_W-CNT_W){1'b0}}, avg_cnt_ff};

   vna_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_go),
      .radicand (sq_ff),
      .root     (root),
      .stat     (sqrt_stat)
   );

   vna_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (quo),
      .stat     (div_stat)
   );

   // quotients above one are clamped to one
   assign q_clip = (quo > DVD_W'(ONE_Q14)) ? ONE_Q14 : quo[NORM_W-1:0];
   assign q_neg  = face_ff ? sgn_ff[comp_ff] : avg_sum_ff[comp_ff][SUM_W-1];
   assign q_res  = q_neg ? NORM_W'(-q_clip) : q_clip;

   // saturating corner update
   logic signed [SUM_W-1:0] old_sum [3];
   logic signed [SUM_W-1:0] new_sum [3];
   logic signed [SUM_W:0]   wide_sum [3];
   logic [CNT_W-1:0]        new_cnt;

   assign old_sum[0] = acc_q_ff.x;
   assign old_sum[1] = acc_q_ff.y;
   assign old_sum[2] = acc_q_ff.z;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         wide_sum[j] = {old_sum[j][SUM_W-1], old_sum[j]}
                     + {{(SUM_W+1-NORM_W){r_ff[j][NORM_W-1]}}, r_ff[j]};
         if (wide_sum[j][SUM_W] != wide_sum[j][SUM_W-1]) begin
            new_sum[j] = wide_sum[j][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            new_sum[j] = wide_sum[j][SUM_W-1:0];
         end
      end
      new_cnt = (acc_q_ff.cnt == CNT_MAX) ? CNT_MAX : acc_q_ff.cnt + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(MAX_VERTICES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (in_op)
                  OP_FACE: state_in = face_ok ? ST_RD_A : ST_RESP;
                  OP_READ: state_in = vi_ok ? ST_AVG_RD : ST_RESP;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_A:   state_in = ST_RD_B;
         ST_RD_B:   state_in = ST_RD_C;
         ST_RD_C:   state_in = ST_EDGE;
         ST_EDGE:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_ACC;
         ST_ACC:    state_in = (mul_ff == 3'd5) ? ST_MAG : ST_MUL;
         ST_MAG:    state_in = ST_SHIFT;
         ST_SHIFT:  state_in = too_big ? ST_SHIFT : ST_SQ;
         ST_SQ:     state_in = ST_SQ_ACC;
         ST_SQ_ACC: begin
            if (comp_ff == 2'd2) begin
               state_in = (sq_in == '0) ? ST_UPD_RD : ST_SQRT_GO;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQRT_GO:   state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: state_in = sqrt_stat.done ? ST_DIV_GO : ST_SQRT_WAIT;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (comp_ff == 2'd2) begin
                  state_in = face_ff ? ST_UPD_RD : ST_RESP;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_UPD_RD:  state_in = ST_UPD_WR;
         ST_UPD_WR:  state_in = (comp_ff == 2'd2) ? ST_RESP : ST_UPD_RD;
         ST_AVG_RD:  state_in = ST_AVG_CHK;
         ST_AVG_CHK: state_in = (acc_q_ff.cnt == '0) ? ST_RESP : ST_DIV_GO;
         ST_RESP:    state_in = rsp_tready ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      sqrt_go     = 1'b0;
      div_go      = 1'b0;
      coord_we    = 1'b0;
      coord_waddr = vi17[AW-1:0];
      coord_wdata = in_coord;
      coord_raddr = addr_ff[0];
      acc_we      = 1'b0;
      acc_waddr   = vi17[AW-1:0];
      acc_wdata   = '0;
      acc_raddr   = addr_ff[0];
      unique case (state_ff)
         ST_CLEAR: begin
            acc_we    = 1'b1;
            acc_waddr = clr_ff;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && in_op == OP_STORE && vi_ok) begin
               coord_we = 1'b1;
               acc_we   = 1'b1;
            end
         end
         ST_RD_B:    coord_raddr = addr_ff[1];
         ST_RD_C:    coord_raddr = addr_ff[2];
         ST_SQRT_GO: sqrt_go = 1'b1;
         ST_DIV_GO:  div_go = 1'b1;
         ST_UPD_RD:  acc_raddr = addr_ff[comp_ff];
         ST_UPD_WR: begin
            acc_we    = 1'b1;
            acc_waddr = addr_ff[comp_ff];
            acc_wdata = '{cnt: new_cnt, z: new_sum[2], y: new_sum[1], x: new_sum[0]};
         end
         ST_RESP: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               face_ff    <= (in_op == OP_FACE);
               kind_ff    <= (in_op == OP_READ) ? KIND_VERTEX : KIND_FACE;
               addr_ff[0] <= (in_op == OP_READ) ? vi17[AW-1:0] : a17[AW-1:0];
               addr_ff[1] <= b17[AW-1:0];
               addr_ff[2] <= c17[AW-1:0];
               inv_ff     <= 1'b1;
               mul_ff     <= '0;
               comp_ff    <= '0;
               for (int j = 0; j < 3; j++) r_ff[j] <= '0;
            end
         end
         ST_RD_B: va_ff <= coord_q_ff;
         ST_RD_C: begin
            e0_ff[0] <= EDGE_W'(coord_q_ff.x) - EDGE_W'(va_ff.x);
            e0_ff[1] <= EDGE_W'(coord_q_ff.y) - EDGE_W'(va_ff.y);
            e0_ff[2] <= EDGE_W'(coord_q_ff.z) - EDGE_W'(va_ff.z);
         end
         ST_EDGE: begin
            e1_ff[0] <= EDGE_W'(coord_q_ff.x) - EDGE_W'(va_ff.x);
            e1_ff[1] <= EDGE_W'(coord_q_ff.y) - EDGE_W'(va_ff.y);
            e1_ff[2] <= EDGE_W'(coord_q_ff.z) - EDGE_W'(va_ff.z);
         end
         ST_MUL, ST_SQ: prod_ff <= mul_a * mul_b;
         ST_ACC: begin
            // even steps open a component, odd steps subtract the second term
            if (mul_ff[0]) begin
               n_ff[mul_ff[2:1]] <= n_ff[mul_ff[2:1]] - prod_x;
            end else begin
               n_ff[mul_ff[2:1]] <= prod_x;
            end
            mul_ff <= mul_ff + 1'b1;
         end
         ST_MAG: begin
            for (int j = 0; j < 3; j++) begin
               sgn_ff[j] <= n_ff[j][CROSS_W-1];
               m_ff[j]   <= n_ff[j][CROSS_W-1] ? MAG_W'(-n_ff[j]) : n_ff[j][MAG_W-1:0];
            end
            comp_ff <= '0;
            sq_ff   <= '0;
         end
         ST_SHIFT: begin
            if (too_big) begin
               for (int j = 0; j < 3; j++) m_ff[j] <= m_ff[j] >> 1;
            end
         end
         ST_SQ_ACC: begin
            sq_ff <= sq_in;
            if (comp_ff == 2'd2) begin
               comp_ff <= '0;
               inv_ff  <= (sq_in == '0);
            end else begin
               comp_ff <= comp_ff + 1'b1;
            end
         end
         ST_SQRT_WAIT: begin
            if (sqrt_stat.done) len_ff <= root;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               r_ff[comp_ff] <= q_res;
               comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 1'b1;
            end
         end
         ST_UPD_WR: comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 1'b1;
         ST_AVG_CHK: begin
            avg_sum_ff[0] <= acc_q_ff.x;
            avg_sum_ff[1] <= acc_q_ff.y;
            avg_sum_ff[2] <= acc_q_ff.z;
            avg_cnt_ff    <= acc_q_ff.cnt;
            inv_ff        <= (acc_q_ff.cnt == '0);
            comp_ff       <= '0;
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {r_ff[2], r_ff[1], r_ff[0]};
   assign rsp_tuser = {inv_ff, kind_ff};

`ifndef SYNTHESIS
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sqrt_stat.busy && div_stat.busy))
      else $error("root and divider running together");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("invalid result carries a nonzero normal");

   a_face_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_FACE && !rsp_tuser[1] |-> rsp_tdata != '0)
      else $error("valid face normal is zero");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (sqrt_stat.busy || div_stat.busy) |-> !req_tready && !rsp_tvalid)
      else $error("handshake open while a unit runs");
`endif

endmodule

FILE: sv/vna_sqrt.sv
module vna_sqrt import vna_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic [ROOT_W-1:0] root,
   output unit_stat_type     stat
);

   localparam int CW = $clog2(ROOT_W);

   logic [SQ_W-1:0]     rad_ff;
   logic [ROOT_W+1:0]   rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [CW-1:0]       cnt_ff;
   logic                run_ff;
   logic                done_ff;
   logic [ROOT_W+3:0]   rem_sh;
   logic [ROOT_W+3:0]   trial;
   logic                fits;

   // one result bit per cycle, two radicand bits brought down
   assign rem_sh = {rem_ff, rad_ff[SQ_W-1 -: 2]};
   assign trial  = (ROOT_W+4)'({root_ff, 2'b01});
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(ROOT_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff <= {rad_ff[SQ_W-3:0], 2'b00};
         if (fits) begin
            rem_ff  <= (ROOT_W+2)'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[ROOT_W+1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign root      = root_ff;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

endmodule

FILE: sv/vna_div.sv
module vna_div import vna_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output unit_stat_type    stat
);

   localparam int CW = $clog2(DVD_W);

   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DVS_W:0]   rem_sh;
   logic             fits;

   // restoring division, quotient bits shift into the dividend register
   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], fits};
         if (fits) begin
            rem_ff <= DVS_W'(rem_sh - {1'b0, dvs_ff});
         end else begin
            rem_ff <= rem_sh[DVS_W-1:0];
         end
      end
   end

   assign quotient  = dvd_ff;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

endmodule
